// ===== rtl/wsfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Phase codes, event and error codes, and the command item that travels
// from the header parser to the unmask stage.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // Parser phase, one-hot
   typedef enum logic [5:0] {
      PH_FIRST   = 6'b000001,
      PH_SECOND  = 6'b000010,
      PH_EXTLEN  = 6'b000100,
      PH_KEY     = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_ERROR   = 6'b100000
   } phase_type;

   // Result event codes
   localparam logic [1:0] EV_HEADER  = 2'd0;
   localparam logic [1:0] EV_PAYLOAD = 2'd1;
   localparam logic [1:0] EV_ERROR   = 2'd2;
   localparam logic [1:0] EV_DISCARD = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_OPCODE   = 3'd1;
   localparam logic [2:0] ERR_RSV      = 3'd2;
   localparam logic [2:0] ERR_FIN      = 3'd3;
   localparam logic [2:0] ERR_UNMASKED = 3'd4;
   localparam logic [2:0] ERR_LEN_MSB  = 3'd5;

   // Opcodes accepted by the parser
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Length field markers in the second header byte
   localparam logic [6:0] LEN_EXT16 = 7'h7E;
   localparam logic [6:0] LEN_EXT64 = 7'h7F;

   // Extended length and masking key byte counts
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   localparam int LEN_W = 63;

   // Classified byte handed to the back end
   typedef struct packed {
      logic [1:0]       event_res;
      logic [7:0]       data_byte;
      logic [7:0]       key_byte;
      logic             last_of_frame;
      logic [3:0]       frame_type;
      logic [LEN_W-1:0] payload_size;
      logic [2:0]       error_code;
   } cmd_type;

endpackage

// ===== rtl/wsfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Walks the frame header one byte per item, checks it, collects length and
// masking key, and emits one classified command per accepted byte.
// ----------------------------------------------------------------------------
module wsfd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_take,
   input  logic [7:0]          in_data_byte,
   input  logic                in_restart,
   output wsfd_pkg::cmd_type   cmd
);
   import wsfd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [3:0]       hdr_idx_ff, hdr_idx_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [31:0]      key_ff, key_in;
   logic [1:0]       mask_idx_ff, mask_idx_in;
   logic [2:0]       err_ff, err_in;

   // Current state after an optional restart
   phase_type        cur_phase;
   logic [3:0]       cur_hdr_idx;
   logic [3:0]       cur_opcode;
   logic [LEN_W-1:0] cur_length;
   logic [LEN_W-1:0] cur_left;
   logic [31:0]      cur_key;
   logic [1:0]       cur_mask_idx;

   logic [1:0]       ev;
   logic             last;
   logic [2:0]       code;
   logic [7:0]       key_byte;
   logic [3:0]       hdr_inc;
   logic [7:0]       b;

   assign b = in_data_byte;

   // Restart puts the parser back to its reset state before this byte
   always_comb begin
      if (in_restart) begin
         cur_phase    = PH_FIRST;
         cur_hdr_idx  = '0;
         cur_opcode   = '0;
         cur_length   = '0;
         cur_left     = '0;
         cur_key      = '0;
         cur_mask_idx = '0;
      end else begin
         cur_phase    = phase_ff;
         cur_hdr_idx  = hdr_idx_ff;
         cur_opcode   = opcode_ff;
         cur_length   = length_ff;
         cur_left     = left_ff;
         cur_key      = key_ff;
         cur_mask_idx = mask_idx_ff;
      end
   end

   // Select the key byte for the current payload position
   always_comb begin
      case (cur_mask_idx)
         2'd0:    key_byte = cur_key[31:24];
         2'd1:    key_byte = cur_key[23:16];
         2'd2:    key_byte = cur_key[15:8];
         default: key_byte = cur_key[7:0];
      endcase
   end

   assign hdr_inc = cur_hdr_idx + 4'd1;

   // Classify the byte and advance the header parser
   always_comb begin
      phase_in    = cur_phase;
      hdr_idx_in  = cur_hdr_idx;
      opcode_in   = cur_opcode;
      length_in   = cur_length;
      left_in     = cur_left;
      key_in      = cur_key;
      mask_idx_in = cur_mask_idx;
      err_in      = in_restart ? ERR_NONE : err_ff;
      ev          = EV_HEADER;
      last        = 1'b0;
      code        = ERR_NONE;
      case (cur_phase)
         PH_ERROR: begin
            ev = EV_DISCARD;
         end
         PH_SECOND: begin
            if (!b[7]) begin
               code = ERR_UNMASKED;
            end else if (b[6:0] == LEN_EXT16) begin
               hdr_idx_in = EXT16_BYTES;
               phase_in   = PH_EXTLEN;
            end else if (b[6:0] == LEN_EXT64) begin
               hdr_idx_in = EXT64_BYTES;
               phase_in   = PH_EXTLEN;
            end else begin
               length_in  = {{(LEN_W-7){1'b0}}, b[6:0]};
               hdr_idx_in = '0;
               phase_in   = PH_KEY;
            end
         end
         PH_EXTLEN: begin
            if (cur_hdr_idx == EXT64_BYTES && b[7]) begin
               code = ERR_LEN_MSB;
            end else begin
               length_in  = {cur_length[LEN_W-9:0], b};
               hdr_idx_in = cur_hdr_idx - 4'd1;
               if (cur_hdr_idx == 4'd1) begin
                  phase_in = PH_KEY;
               end
            end
         end
         PH_KEY: begin
            key_in     = {cur_key[23:0], b};
            hdr_idx_in = hdr_inc;
            if (hdr_inc >= KEY_BYTES) begin
               hdr_idx_in  = '0;
               left_in     = cur_length;
               mask_idx_in = '0;
               if (cur_length == '0) begin
                  last     = 1'b1;
                  phase_in = PH_FIRST;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            ev          = EV_PAYLOAD;
            mask_idx_in = cur_mask_idx + 2'd1;
            left_in     = cur_left - {{(LEN_W-1){1'b0}}, 1'b1};
            if (cur_left == {{(LEN_W-1){1'b0}}, 1'b1}) begin
               last     = 1'b1;
               phase_in = PH_FIRST;
            end
         end
         default: begin
            // First header byte
            opcode_in   = b[3:0];
            length_in   = '0;
            left_in     = '0;
            key_in      = '0;
            mask_idx_in = '0;
            hdr_idx_in  = '0;
            if (!(b[3:0] inside {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG})) begin
               code = ERR_OPCODE;
            end else if (b[6:4] != 3'b000) begin
               code = ERR_RSV;
            end else if (!b[7]) begin
               code = ERR_FIN;
            end else begin
               phase_in = PH_SECOND;
            end
         end
      endcase
      // Errors stick until restart
      if (code != ERR_NONE) begin
         ev       = EV_ERROR;
         err_in   = code;
         phase_in = PH_ERROR;
         last     = 1'b0;
      end
   end

   // Build the command for the back end
   always_comb begin
      cmd.event_res     = ev;
      cmd.data_byte     = b;
      cmd.key_byte      = key_byte;
      cmd.last_of_frame = last;
      cmd.frame_type    = opcode_in;
      cmd.payload_size  = length_in;
      cmd.error_code    = (phase_in == PH_ERROR) ? err_in : ERR_NONE;
   end

   // Advance state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         hdr_idx_ff  <= '0;
         opcode_ff   <= '0;
         length_ff   <= '0;
         left_ff     <= '0;
         key_ff      <= '0;
         mask_idx_ff <= '0;
         err_ff      <= ERR_NONE;
      end else if (in_take) begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         opcode_ff   <= opcode_in;
         length_ff   <= length_in;
         left_ff     <= left_in;
         key_ff      <= key_in;
         mask_idx_ff <= mask_idx_in;
         err_ff      <= err_in;
      end
   end

endmodule

// ===== rtl/wsfd_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer command queue
// Short first-in first-out buffer between the parser and the unmask stage.
// ----------------------------------------------------------------------------
module wsfd_cmd_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  wsfd_pkg::cmd_type wr_cmd,
   output logic              full,
   input  logic              rd_en,
   output wsfd_pkg::cmd_type rd_cmd,
   output logic              empty
);
   import wsfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_cmd = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ===== rtl/wsfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Unmasks payload bytes and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module wsfd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_empty,
   input  wsfd_pkg::cmd_type               cmd,
   output logic                            cmd_take,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [1:0]                      rsp_event_res,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_last_of_frame,
   output logic [3:0]                      rsp_frame_type,
   output logic [wsfd_pkg::LEN_W-1:0]      rsp_payload_size,
   output logic [2:0]                      rsp_error_code
);
   import wsfd_pkg::*;

   logic             valid_ff;
   logic [1:0]       event_ff;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff;
   logic [3:0]       type_ff;
   logic [LEN_W-1:0] size_ff;
   logic [2:0]       err_ff;

   // Load a new result when the output stage is free or being drained
   assign cmd_take  = !cmd_empty && (!valid_ff || rsp_pop);
   assign rsp_empty = !valid_ff;

   // Unmask payload bytes, zero otherwise
   assign byte_in = (cmd.event_res == EV_PAYLOAD) ? (cmd.data_byte ^ cmd.key_byte) : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd_take) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         event_ff <= cmd.event_res;
         byte_ff  <= byte_in;
         last_ff  <= cmd.last_of_frame;
         type_ff  <= cmd.frame_type;
         size_ff  <= cmd.payload_size;
         err_ff   <= cmd.error_code;
      end
   end

   assign rsp_event_res     = event_ff;
   assign rsp_payload_byte  = byte_ff;
   assign rsp_last_of_frame = last_ff;
   assign rsp_frame_type    = type_ff;
   assign rsp_payload_size  = size_ff;
   assign rsp_error_code    = err_ff;

endmodule

// ===== rtl/websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses client-to-server frames byte by byte and returns unmasked payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive req_data_byte and req_restart,
//   raise req_push; the byte is taken at an edge where req_full is low.
//   Raise req_restart with a byte to drop all state and treat that byte as
//   the first header byte of a new frame.
//   Result side is a queue read port: while rsp_empty is low the oldest
//   result sits on the rsp_ ports; rsp_pop takes it. Every byte gives one
//   result: header taken, payload byte (unmasked), error, or discarded.
//   A byte passes the queue and output register before rsp_empty goes low.
//   Throughput is one byte per cycle while req_full is low; the parser
//   decides each byte combinationally and the unmask stage runs behind a
//   CMD_DEPTH-entry queue. When the receiver stalls, results collect in
//   the output register and the queue; req_full rises once both are occupied.
//   Reset is synchronous and active high; it empties the queue and output
//   stage and returns the parser to waiting for a first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
   parameter int CMD_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_restart,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [1:0]                    rsp_event_res,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_last_of_frame,
   output logic [3:0]                    rsp_frame_type,
   output logic [wsfd_pkg::LEN_W-1:0]    rsp_payload_size,
   output logic [2:0]                    rsp_error_code
);
   import wsfd_pkg::*;

   logic    in_take;
   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    queue_take;

   assign req_full = queue_full;
   assign in_take  = req_push && !queue_full;

   wsfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_take      (in_take),
      .in_data_byte (req_data_byte),
      .in_restart   (req_restart),
      .cmd          (front_cmd)
   );

   wsfd_cmd_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (in_take),
      .wr_cmd (front_cmd),
      .full   (queue_full),
      .rd_en  (queue_take),
      .rd_cmd (queue_cmd),
      .empty  (queue_empty)
   );

   wsfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_empty         (queue_empty),
      .cmd               (queue_cmd),
      .cmd_take          (queue_take),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_res     (rsp_event_res),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_payload_size  (rsp_payload_size),
      .rsp_error_code    (rsp_error_code)
   );

endmodule
